// ----- hw/rtl/hrfh_pkg.sv -----
package hrfh_pkg;

   // Character codes recognized by the record parser.
   localparam logic [7:0] CHAR_COLON   = 8'h3A;
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_NINE    = 8'h39;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_F = 8'h46;
   localparam logic [7:0] ALPHA_BIAS   = 8'd55;

   localparam int unsigned POS_W  = 10;
   localparam int unsigned IDX_W  = 7;
   localparam int unsigned ADDR_W = 32;
   localparam int unsigned HALF_W = 16;

   localparam logic [POS_W-1:0] POS_MAX    = 10'd1023;
   localparam logic [POS_W-1:0] POS_COUNT0 = 10'd1;
   localparam logic [POS_W-1:0] POS_COUNT1 = 10'd2;
   localparam logic [POS_W-1:0] POS_OFS0   = 10'd3;
   localparam logic [POS_W-1:0] POS_OFS3   = 10'd6;
   localparam logic [POS_W-1:0] POS_DATA0  = 10'd9;

   // Register map: the word index is taken from bit 2 of the byte address.
   localparam int unsigned CSR_ADDR_W = 3;
   localparam logic        REG_FLASH_BASE = 1'b0;
   localparam logic [ADDR_W-1:0] FLASH_BASE_RESET = 32'h0800_0000;

   typedef struct packed {
      logic [ADDR_W-1:0] write_address;
      logic [HALF_W-1:0] write_halfword;
      logic              last_of_record;
   } hrfh_beat_type;

   function automatic logic [3:0] hex_digit(input logic [7:0] c);
      logic [7:0] v;
      begin
         v = 8'd0;
         if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
            v = c - CHAR_ZERO;
         end else if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_F) begin
            v = c - ALPHA_BIAS;
         end
         return v[3:0];
      end
   endfunction

endpackage

// ----- hw/rtl/hrfh_parse.sv -----
module hrfh_parse (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        char_accept,
   input  logic [7:0]                  ascii_char,
   input  logic [hrfh_pkg::ADDR_W-1:0] flash_base,
   output logic                        emit,
   output hrfh_pkg::hrfh_beat_type     beat
);
   import hrfh_pkg::*;

   logic [POS_W-1:0]  pos_ff, pos_in;
   logic              in_record_ff, in_record_in;
   logic [7:0]        count_ff, count_in;
   logic [15:0]       offset_ff, offset_in;
   logic [11:0]       acc_ff, acc_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;

   logic [3:0]        digit;
   logic [IDX_W-1:0]  half;
   logic              group_end;

   assign digit     = hex_digit(ascii_char);
   assign half      = count_ff[7:1];
   // Position 9 starts the data, so every fourth data digit sits at a multiple of four.
   assign group_end = (pos_ff[1:0] == 2'b00);

   always_comb begin
      pos_in       = pos_ff;
      in_record_in = in_record_ff;
      count_in     = count_ff;
      offset_in    = offset_ff;
      acc_in       = acc_ff;
      idx_in       = idx_ff;
      emit         = 1'b0;
      if (char_accept) begin
         if (ascii_char == CHAR_COLON) begin
            in_record_in = 1'b1;
            pos_in       = POS_COUNT0;
            count_in     = 8'd0;
            offset_in    = 16'd0;
            acc_in       = 12'd0;
            idx_in       = '0;
         end else if (in_record_ff) begin
            if (pos_ff == POS_COUNT0 || pos_ff == POS_COUNT1) begin
               count_in = {count_ff[3:0], digit};
            end else if (pos_ff >= POS_OFS0 && pos_ff <= POS_OFS3) begin
               offset_in = {offset_ff[11:0], digit};
            end else if (pos_ff >= POS_DATA0 && idx_ff < half) begin
               if (group_end) begin
                  emit   = 1'b1;
                  idx_in = idx_ff + 1'b1;
                  acc_in = 12'd0;
               end else begin
                  acc_in = {acc_ff[7:0], digit};
               end
            end
            if (pos_ff != POS_MAX) begin
               pos_in = pos_ff + 1'b1;
            end
         end
      end
   end

   always_comb begin
      beat.write_address  = (flash_base | {16'd0, offset_ff})
                            + {{(ADDR_W-IDX_W-1){1'b0}}, idx_ff, 1'b0};
      beat.write_halfword = {acc_ff, digit};
      beat.last_of_record = ((idx_ff + 1'b1) == half);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         in_record_ff <= 1'b0;
         count_ff     <= 8'd0;
         offset_ff    <= 16'd0;
         acc_ff       <= 12'd0;
         idx_ff       <= '0;
      end else begin
         pos_ff       <= pos_in;
         in_record_ff <= in_record_in;
         count_ff     <= count_in;
         offset_ff    <= offset_in;
         acc_ff       <= acc_in;
         idx_ff       <= idx_in;
      end
   end

   // A halfword can only complete on a group boundary inside an open record.
   a_emit_in_record: assert property (@(posedge clock) disable iff (reset)
      emit |-> (in_record_ff && pos_ff >= POS_DATA0 + 10'd3 && pos_ff[1:0] == 2'b00))
      else $error("halfword emitted outside a data group boundary");

   // The halfword index never runs past half the byte count.
   a_idx_bound: assert property (@(posedge clock) disable iff (reset)
      idx_ff <= half || !in_record_ff || pos_ff < POS_DATA0)
      else $error("halfword index passed the record length");

endmodule

// ----- hw/rtl/hex_record_to_flash_halfwords.sv -----
// Channel | Direction | Beat contents
// req_    | in        | ascii_char, one record character
// rsp_    | out       | write_address, write_halfword, last_of_record
// csr_    | in        | APB write/read of flash_base at byte address 0
//
// One character is taken every cycle while req_ready is high; the halfword that a
// character completes is registered for rsp_. An output register plus one skid
// register sit after the parser, so req_ready drops only when both hold a beat.
// Reset (synchronous) closes any open record and sets flash_base to 0x0800_0000.
module hex_record_to_flash_halfwords (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [7:0]                      req_ascii_char,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [31:0]                     rsp_write_address,
   output logic [15:0]                     rsp_write_halfword,
   output logic                            rsp_last_of_record,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [hrfh_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]                     csr_pwdata,
   output logic [31:0]                     csr_prdata,
   output logic                            csr_pready
);
   import hrfh_pkg::*;

   logic [ADDR_W-1:0] base_ff;
   logic              accept;
   logic              emit;
   hrfh_beat_type     beat;
   logic              out_valid_ff, out_valid_in;
   hrfh_beat_type     out_ff, out_in;
   logic              skid_valid_ff, skid_valid_in;
   hrfh_beat_type     skid_ff, skid_in;
   logic              push, pop;

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == REG_FLASH_BASE) ? base_ff : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= FLASH_BASE_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready
                   && csr_paddr[2] == REG_FLASH_BASE) begin
         base_ff <= csr_pwdata;
      end
   end

   assign req_ready = !skid_valid_ff;
   assign accept    = req_valid && req_ready;

   hrfh_parse u_parse (
      .clock       (clock),
      .reset       (reset),
      .char_accept (accept),
      .ascii_char  (req_ascii_char),
      .flash_base  (base_ff),
      .emit        (emit),
      .beat        (beat)
   );

   assign push = emit;
   assign pop  = out_valid_ff && rsp_ready;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (!out_valid_ff) begin
         out_valid_in = push;
         out_in       = beat;
      end else if (pop) begin
         if (skid_valid_ff) begin
            // Skid holds the older beat; no new beat can arrive while it is full.
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = push;
            out_in       = beat;
         end
      end else if (push) begin
         skid_valid_in = 1'b1;
         skid_in       = beat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_write_address  = out_ff.write_address;
   assign rsp_write_halfword = out_ff.write_halfword;
   assign rsp_last_of_record = out_ff.last_of_record;

   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid register full while output register is empty");

   a_skid_drains: assert property (@(posedge clock) disable iff (reset)
      (pop && skid_valid_ff) |=> !skid_valid_ff)
      else $error("skid register did not drain after output beat");

   a_stall_to_skid: assert property (@(posedge clock) disable iff (reset)
      (push && out_valid_ff && !rsp_ready) |=> (skid_valid_ff && !req_ready))
      else $error("stalled halfword not captured in skid register");

endmodule
